FILE: src/olt_pkg.sv
// Package for the ordered list table engine.
// Holds the entry width, request and status codes and the cell control struct.
// No dependencies.
package olt_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic load;        // copy entry into the scan stage and compare it
    logic shift;       // scan stage takes the right neighbor's scan stage
    logic take_left;   // entry takes the left neighbor's entry
    logic take_right;  // entry takes the right neighbor's entry
    logic write_new;   // entry takes the new data bus
  } olt_cell_ctl_t;

endpackage

FILE: src/olt_cell.sv
// One cell of the list chain: one stored entry plus one stage of the scan line.
// Depends on olt_pkg for the entry width and the cell control struct.
module olt_cell
  import olt_pkg::*;
(
  input  logic              clk,
  input  olt_cell_ctl_t     ctl,
  input  logic              in_range,
  input  logic [DATA_W-1:0] cmp_value,
  input  logic [DATA_W-1:0] new_data,
  input  logic [DATA_W-1:0] left_entry,
  input  logic [DATA_W-1:0] right_entry,
  input  logic              right_match,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] entry,
  output logic              scan_match,
  output logic [DATA_W-1:0] scan_data
);

  always_ff @(posedge clk) begin
    if (ctl.write_new) begin
      entry <= new_data;
    end else if (ctl.take_left) begin
      entry <= left_entry;
    end else if (ctl.take_right) begin
      entry <= right_entry;
    end
  end

  // The scan line is loaded in parallel and then drains toward cell zero,
  // one cell per cycle while shift is set, so the head always shows the entry under the cursor.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      scan_match <= in_range && (entry == cmp_value);
      scan_data  <= entry;
    end else if (ctl.shift) begin
      scan_match <= right_match;
      scan_data  <= right_data;
    end
  end

endmodule

FILE: src/ordered_list_table_engine.sv
// Top level of the ordered list table engine: control, length and result register.
// Depends on olt_pkg and olt_cell.
//
//  channel | direction | fields (tdata, lowest bit first)
//  s_axis  | in        | req_type[1:0] position[8:2] value[40:9] new_value[72:41]
//  m_axis  | out       | status[1:0] found_position[8:2] removed_value[40:9]
//                        list_length[47:41]
//
// Insert and a rejected delete skip the scan. A delete at position p scans until
// the cursor reaches p-1; a locate or modify scans until the head cell hits or the
// cursor reaches the list length: the scan line moves one cell per cycle.
// Synchronous reset empties the list; stored entries are not cleared.
// A request is taken only when the control is idle; a stalled result waits in the
// output register while the next request is taken.
module ordered_list_table_engine
  import olt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // req_type, position, value, new_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status, found_position, removed_value, list_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]        state;
  logic [1:0]        req_op;
  logic [POS_W-1:0]  req_pos;
  logic [DATA_W-1:0] req_value;
  logic [DATA_W-1:0] req_new_value;
  logic [CW-1:0]     k;
  logic [CW-1:0]     count;
  logic [1:0]        res_status;
  logic [DATA_W-1:0] res_removed;

  logic [1:0]        in_op;
  logic [POS_W-1:0]  in_pos;
  logic [WW-1:0]     in_pos_w;
  logic [WW-1:0]     count_w;
  logic [WW-1:0]     pm1_w;
  logic              accept;
  logic              out_free;
  logic              apply;
  logic [CW-1:0]     count_next;
  logic [WW-1:0]     length_w;
  logic [POS_W-1:0]  fpos;
  logic [DATA_W-1:0] new_data;
  logic              shift_en;

  logic [DATA_W-1:0] ent  [CAPACITY];
  logic [DATA_W-1:0] sdat [CAPACITY];
  logic              smat [CAPACITY];
  olt_cell_ctl_t     ctl  [CAPACITY];

  assign in_op    = s_axis_tdata[1:0];
  assign in_pos   = s_axis_tdata[8:2];
  assign in_pos_w = WW'(in_pos);
  assign count_w  = WW'(count);
  assign pm1_w    = WW'(req_pos) - WW'(1);

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign apply         = (state == S_FINISH) && out_free && (res_status == ST_OK);
  assign new_data      = (req_op == OP_MODIFY) ? req_new_value : req_value;

  // The scan keeps draining while the cursor has not reached its stop point.
  always_comb begin
    shift_en = 1'b0;
    if (state == S_SCAN) begin
      if (req_op == OP_DELETE) begin
        shift_en = (WW'(k) != pm1_w);
      end else begin
        shift_en = !smat[0] && (k != count);
      end
    end
  end

  always_comb begin
    count_next = count;
    if (apply && req_op == OP_INSERT) begin
      count_next = count + CW'(1);
    end else if (apply && req_op == OP_DELETE) begin
      count_next = count - CW'(1);
    end
  end

  assign length_w = WW'(count_next);
  assign fpos     = POS_W'(WW'(k) + WW'(1));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_entry;
    logic [DATA_W-1:0] right_entry;
    logic              right_match;
    logic [DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_inner
      assign left_entry = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
      assign right_match = 1'b0;
      assign right_data  = '0;
    end else begin : g_mid
      assign right_entry = ent[i+1];
      assign right_match = smat[i+1];
      assign right_data  = sdat[i+1];
    end

    assign ctl[i].load       = accept;
    assign ctl[i].shift      = shift_en;
    assign ctl[i].take_left  = apply && (req_op == OP_INSERT) && (WW'(i) > pm1_w);
    assign ctl[i].take_right = apply && (req_op == OP_DELETE) && (WW'(i) >= pm1_w);
    assign ctl[i].write_new  = apply &&
                               (((req_op == OP_INSERT) && (WW'(i) == pm1_w)) ||
                                ((req_op == OP_MODIFY) && (k == CW'(i))));

    olt_cell u_cell (
      .clk         (clk),
      .ctl         (ctl[i]),
      .in_range    (CW'(i) < count),
      .cmp_value   (s_axis_tdata[40:9]),
      .new_data    (new_data),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .right_match (right_match),
      .right_data  (right_data),
      .entry       (ent[i]),
      .scan_match  (smat[i]),
      .scan_data   (sdat[i])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op        <= in_op;
      req_pos       <= in_pos;
      req_value     <= s_axis_tdata[40:9];
      req_new_value <= s_axis_tdata[72:41];
      res_removed   <= '0;
      if (in_op == OP_INSERT) begin
        if (in_pos_w == '0 || in_pos_w > count_w + WW'(1)) begin
          res_status <= ST_BAD_POS;
        end else if (count_w >= WW'(CAPACITY)) begin
          res_status <= ST_FULL;
        end else begin
          res_status <= ST_OK;
        end
      end else if (in_op == OP_DELETE &&
                   (in_pos_w == '0 || in_pos_w > count_w)) begin
        res_status <= ST_BAD_POS;
      end else begin
        res_status <= ST_OK;
      end
    end else if (state == S_SCAN && !shift_en) begin
      if (req_op == OP_DELETE) begin
        res_removed <= sdat[0];
      end else if (!smat[0]) begin
        res_status <= ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k <= '0;
    end else if (shift_en) begin
      k <= k + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_op == OP_INSERT ||
                (in_op == OP_DELETE && (in_pos_w == '0 || in_pos_w > count_w))) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!shift_en) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (state == S_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
        count         <= count_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      m_axis_tdata[1:0]   <= res_status;
      m_axis_tdata[8:2]   <= (res_status == ST_OK &&
                              (req_op == OP_LOCATE || req_op == OP_MODIFY)) ? fpos : '0;
      m_axis_tdata[40:9]  <= res_removed;
      m_axis_tdata[47:41] <= length_w[POS_W-1:0];
    end
  end

  // The list never grows past the store.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_w <= WW'(CAPACITY))
    else $error("list length exceeds capacity");

  // The scan cursor never runs past the end of the list.
  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (k <= count))
    else $error("scan cursor beyond list length");

  // A finishing request always leaves a result behind and returns to idle.
  a_finish_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (m_axis_tvalid && state == S_IDLE))
    else $error("finished request left no result");

  // The length only moves when a request completes.
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !(state == S_FINISH && out_free) |=> $stable(count))
    else $error("list length changed outside completion");

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for ordered_list_table_engine, a list store with insert, delete,
// locate and modify requests. It keeps its own copy of the list to predict each result.
// Depends on olt_pkg and the engine RTL.
`timescale 1ns / 100ps

module tb_top;
  import olt_pkg::*;

  localparam int LIST_CAP = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [1:0]        req_type;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] new_value;
  } list_request_t;

  typedef struct {
    logic [1:0]        status;
    logic [POS_W-1:0]  found_position;
    logic [DATA_W-1:0] removed_value;
    logic [POS_W-1:0]  list_length;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;   // req_type, position, value, new_value
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // status, found_position, removed_value, list_length

  // Shadow copy of the list held by the engine.
  logic [DATA_W-1:0] shadow_entries [LIST_CAP];
  int                shadow_len;

  list_result_t pending_results [$];
  list_result_t got_result;
  list_result_t want_result;

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int idle_cycles;

  ordered_list_table_engine #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_result_t predict_list_op(input list_request_t r);
    list_result_t res;
    int pos;
    int hit;
    res.status = ST_OK;
    res.found_position = '0;
    res.removed_value = '0;
    pos = int'(r.position);
    hit = -1;
    case (r.req_type)
      OP_INSERT: begin
        if (pos < 1 || pos > shadow_len + 1) begin
          res.status = ST_BAD_POS;
        end else if (shadow_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          for (int k = shadow_len; k >= pos; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[pos-1] = r.value;
          shadow_len++;
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > shadow_len) begin
          res.status = ST_BAD_POS;
        end else begin
          res.removed_value = shadow_entries[pos-1];
          for (int k = pos; k < shadow_len; k++) shadow_entries[k-1] = shadow_entries[k];
          shadow_len--;
        end
      end
      default: begin
        for (int k = 0; k < shadow_len; k++) begin
          if (hit < 0 && shadow_entries[k] == r.value) hit = k;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          res.found_position = POS_W'(hit + 1);
          if (r.req_type == OP_MODIFY) shadow_entries[hit] = r.new_value;
        end
      end
    endcase
    res.list_length = POS_W'(shadow_len);
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic [1:0] req_type, input int position,
                              input logic [DATA_W-1:0] value,
                              input logic [DATA_W-1:0] new_value);
    list_request_t r;
    r.req_type = req_type;
    r.position = POS_W'(position);
    r.value = value;
    r.new_value = new_value;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, r.new_value, r.value, r.position, r.req_type};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(predict_list_op(r));
    @(negedge clk);
  endtask

  // Half the time a small pool of values so that searches hit, else an extreme or a random value.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return DATA_W'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  task automatic test_directed();
    send_request(OP_DELETE, 1, 0, 0);           // delete from an empty list
    send_request(OP_LOCATE, 0, 0, 0);
    send_request(OP_MODIFY, 0, 0, 1);
    send_request(OP_INSERT, 0, 1, 0);           // position zero
    send_request(OP_INSERT, 2, 1, 0);           // beyond the end
    send_request(OP_INSERT, 1, 32'h7fff_ffff, 0);
    send_request(OP_INSERT, 2, 32'h8000_0000, 0);
    send_request(OP_INSERT, 1, 0, 0);
    send_request(OP_INSERT, 2, 0, 0);           // duplicate value
    send_request(OP_INSERT, 5, 32'hffff_ffff, 0);
    send_request(OP_INSERT, 7, 3, 0);
    send_request(OP_INSERT, 127, 3, 0);
    send_request(OP_LOCATE, 0, 0, 0);           // first of two equal entries
    send_request(OP_LOCATE, 0, 32'hffff_ffff, 0);
    send_request(OP_LOCATE, 0, 12345, 0);
    send_request(OP_MODIFY, 0, 0, 32'h5a5a_5a5a);
    send_request(OP_MODIFY, 0, 0, 32'hffff_ffff);
    send_request(OP_MODIFY, 0, 99, 1);
    send_request(OP_LOCATE, 0, 32'hffff_ffff, 0);
    send_request(OP_DELETE, 0, 0, 0);
    send_request(OP_DELETE, 6, 0, 0);
    send_request(OP_DELETE, 127, 0, 0);
    send_request(OP_DELETE, 5, 0, 0);
    send_request(OP_DELETE, 1, 0, 0);
    send_request(OP_DELETE, 2, 0, 0);
  endtask

  task automatic test_full_store();
    while (shadow_len < LIST_CAP) begin
      send_request(OP_INSERT, $urandom_range(1, shadow_len + 1), $urandom(), 0);
    end
    send_request(OP_INSERT, LIST_CAP + 1, 7, 0);
    send_request(OP_INSERT, 1, 7, 0);
    send_request(OP_INSERT, LIST_CAP + 2, 7, 0);
    send_request(OP_LOCATE, 0, shadow_entries[LIST_CAP-1], 0);
    send_request(OP_MODIFY, 0, shadow_entries[LIST_CAP-1], 32'h8000_0000);
    send_request(OP_LOCATE, 0, 32'h1234_5678, 0);
    send_request(OP_DELETE, LIST_CAP + 1, 0, 0);
    send_request(OP_DELETE, LIST_CAP, 0, 0);
    while (shadow_len > 0) begin
      send_request(OP_DELETE, $urandom_range(1, shadow_len), 0, 0);
    end
  endtask

  // The list length drifts toward a target that moves now and then, so the run
  // passes through the empty list, the full store and everything in between.
  task automatic test_random(input int n_items);
    int target;
    int roll;
    int ins_pct;
    int del_pct;
    int position;
    logic [1:0] req_type;
    logic [DATA_W-1:0] value;
    target = $urandom_range(0, LIST_CAP);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 3))
          0: target = 0;
          1: target = LIST_CAP;
          default: target = $urandom_range(0, LIST_CAP);
        endcase
      end
      if (shadow_len < target) begin
        ins_pct = 55;
        del_pct = 15;
      end else if (shadow_len > target) begin
        ins_pct = 15;
        del_pct = 55;
      end else begin
        ins_pct = 25;
        del_pct = 25;
      end
      roll = $urandom_range(0, 99);
      if (roll < ins_pct) begin
        req_type = OP_INSERT;
      end else if (roll < ins_pct + del_pct) begin
        req_type = OP_DELETE;
      end else if (roll < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2) begin
        req_type = OP_LOCATE;
      end else begin
        req_type = OP_MODIFY;
      end
      if ($urandom_range(0, 99) < 15) begin
        position = $urandom_range(0, 127);
      end else if (req_type == OP_INSERT) begin
        position = $urandom_range(1, shadow_len + 1);
      end else if (shadow_len > 0) begin
        position = $urandom_range(1, shadow_len);
      end else begin
        position = 1;
      end
      if (shadow_len > 0 && $urandom_range(0, 99) < 30) begin
        value = shadow_entries[$urandom_range(0, shadow_len - 1)];
      end else begin
        value = pick_value();
      end
      send_request(req_type, position, value, pick_value());
    end
  endtask

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_result.status = m_axis_tdata[1:0];
      got_result.found_position = m_axis_tdata[8:2];
      got_result.removed_value = m_axis_tdata[40:9];
      got_result.list_length = m_axis_tdata[47:41];
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.status !== want_result.status) begin
          $error("status: expected %0d, actual %0d", want_result.status, got_result.status);
          fail_count++;
        end
        if (got_result.found_position !== want_result.found_position) begin
          $error("found_position: expected %0d, actual %0d",
                 want_result.found_position, got_result.found_position);
          fail_count++;
        end
        if (got_result.removed_value !== want_result.removed_value) begin
          $error("removed_value: expected %0d, actual %0d",
                 $signed(want_result.removed_value), $signed(got_result.removed_value));
          fail_count++;
        end
        if (got_result.list_length !== want_result.list_length) begin
          $error("list_length: expected %0d, actual %0d",
                 want_result.list_length, got_result.list_length);
          fail_count++;
        end
      end
    end
  end

  // Ends the run when neither side has moved a request for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ordered_list_table_engine verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fail_count = 0;
    shadow_len = 0;
    send_idle_pct = 32;
    recv_idle_pct = 82;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_full_store();
    test_random(320);
    send_idle_pct = 82;
    recv_idle_pct = 32;
    test_random(320);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(320);
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("ordered_list_table_engine verification clean");
    end else begin
      $display("ordered_list_table_engine verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/olt_pkg.sv
src/olt_cell.sv
src/ordered_list_table_engine.sv
bench/tb_top.sv
